// ----- design/rhsl_pkg.sv -----
// ============================================================================
// rhsl_pkg: shared types and constants for the RGB to HSL pixel converter
// Holds the divider lane layout, the sideband that rides along with each
// pixel, and the code that names the largest color component.
// ============================================================================
package rhsl_pkg;

   // Width of a divider remainder and divisor (6 * 255 needs 11 bits).
   localparam int RHSL_DIV_W   = 11;
   // Quotient bits produced by each divider, one per pipeline stage.
   localparam int RHSL_QUO_W   = 17;
   // Width of the saturation numerator d * 131070 + den.
   localparam int RHSL_SNUM_W  = 25;
   // Clock edges from the edge that takes a request to the edge that takes
   // its result.
   localparam int RHSL_LATENCY = RHSL_QUO_W + 4;

   // Which component is the maximum, with red over green over blue on ties.
   typedef enum logic [1:0] {
      RHSL_MAX_RED,
      RHSL_MAX_GREEN,
      RHSL_MAX_BLUE
   } rhsl_max_type;

   // One lane of the restoring divider. The numerator bits still to be
   // brought down sit in the top of numq; quotient bits fill in from below.
   typedef struct packed {
      logic [RHSL_DIV_W-1:0] rem;
      logic [RHSL_QUO_W-1:0] numq;
      logic [RHSL_DIV_W-1:0] dvs;
   } rhsl_lane_type;

   // Per-pixel data that travels beside the dividers.
   typedef struct packed {
      logic       gray;
      logic [7:0] lightness;
   } rhsl_side_type;

endpackage

// ----- design/rhsl_front.sv -----
// ============================================================================
// rhsl_front: component sort and divider setup
// Three register stages: find max, min and the hue difference; form delta
// and the sum; build the numerators and divisors for both dividers.
// ============================================================================
module rhsl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [7:0]             red,
   input  logic [7:0]             green,
   input  logic [7:0]             blue,
   output logic                   out_valid,
   output rhsl_pkg::rhsl_side_type out_side,
   output rhsl_pkg::rhsl_lane_type out_hue,
   output rhsl_pkg::rhsl_lane_type out_sat
);
   import rhsl_pkg::*;

   // Stage 1 registers.
   logic         s1_valid_ff;
   rhsl_max_type s1_sel_ff,  s1_sel_in;
   logic [7:0]   s1_mx_ff,   s1_mx_in;
   logic [7:0]   s1_mn_ff,   s1_mn_in;
   logic [8:0]   s1_diff_ff, s1_diff_in;

   // Stage 2 registers.
   logic         s2_valid_ff;
   rhsl_max_type s2_sel_ff;
   logic [7:0]   s2_d_ff,    s2_d_in;
   logic [8:0]   s2_s_ff,    s2_s_in;
   logic [8:0]   s2_diff_ff;

   // Stage 3 registers.
   logic          s3_valid_ff;
   rhsl_side_type s3_side_ff, s3_side_in;
   rhsl_lane_type s3_hue_ff,  s3_hue_in;
   rhsl_lane_type s3_sat_ff,  s3_sat_in;

   // Stage 3 intermediates.
   logic [RHSL_DIV_W-1:0]  six_d;
   logic [11:0]            base;
   logic [11:0]            n_raw;
   logic [11:0]            n_wrap;
   logic [RHSL_DIV_W-1:0]  n_hue;
   logic [8:0]             den;
   logic [RHSL_SNUM_W-1:0] num_sat;
   logic                   gray;

   // Pick the largest component and the matching hue difference.
   always_comb begin
      if ((red >= green) && (red >= blue)) begin
         s1_sel_in  = RHSL_MAX_RED;
         s1_mx_in   = red;
         s1_diff_in = {1'b0, green} - {1'b0, blue};
      end else if (green >= blue) begin
         s1_sel_in  = RHSL_MAX_GREEN;
         s1_mx_in   = green;
         s1_diff_in = {1'b0, blue} - {1'b0, red};
      end else begin
         s1_sel_in  = RHSL_MAX_BLUE;
         s1_mx_in   = blue;
         s1_diff_in = {1'b0, red} - {1'b0, green};
      end
      s1_mn_in = red;
      if (green < s1_mn_in) begin
         s1_mn_in = green;
      end
      if (blue < s1_mn_in) begin
         s1_mn_in = blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_sel_ff  <= s1_sel_in;
      s1_mx_ff   <= s1_mx_in;
      s1_mn_ff   <= s1_mn_in;
      s1_diff_ff <= s1_diff_in;
   end

   // Delta and sum of the extremes.
   assign s2_d_in = s1_mx_ff - s1_mn_ff;
   assign s2_s_in = {1'b0, s1_mx_ff} + {1'b0, s1_mn_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_sel_ff  <= s1_sel_ff;
      s2_d_ff    <= s2_d_in;
      s2_s_ff    <= s2_s_in;
      s2_diff_ff <= s1_diff_ff;
   end

   // Hue numerator in units of 1/(6d) turn, wrapped into [0, 6d).
   assign six_d = {1'b0, s2_d_ff, 2'b00} + {2'b00, s2_d_ff, 1'b0};

   always_comb begin
      unique case (s2_sel_ff)
         RHSL_MAX_RED:   base = 12'd0;
         RHSL_MAX_GREEN: base = {3'b000, s2_d_ff, 1'b0};
         RHSL_MAX_BLUE:  base = {2'b00, s2_d_ff, 2'b00};
         default:        base = 12'd0;
      endcase
   end

   assign n_raw  = base + {{3{s2_diff_ff[8]}}, s2_diff_ff};
   assign n_wrap = n_raw + {1'b0, six_d};
   assign n_hue  = n_raw[11] ? n_wrap[RHSL_DIV_W-1:0] : n_raw[RHSL_DIV_W-1:0];

   // Saturation denominator and the rounded numerator 2 * 65535 * d + den.
   assign den     = (s2_s_ff < 9'd255) ? s2_s_ff : (9'd510 - s2_s_ff);
   assign num_sat = {s2_d_ff, 17'd0} - {16'd0, s2_d_ff, 1'b0} + {16'd0, den};
   assign gray    = (s2_d_ff == 8'd0);

   // Load both divider lanes; a gray pixel gets a harmless divide by one.
   always_comb begin
      s3_side_in.gray      = gray;
      s3_side_in.lightness = s2_s_ff[8:1];
      if (gray) begin
         s3_hue_in.rem  = '0;
         s3_hue_in.numq = '0;
         s3_hue_in.dvs  = RHSL_DIV_W'(1);
         s3_sat_in.rem  = '0;
         s3_sat_in.numq = '0;
         s3_sat_in.dvs  = RHSL_DIV_W'(1);
      end else begin
         s3_hue_in.rem  = n_hue;
         s3_hue_in.numq = '0;
         s3_hue_in.dvs  = six_d;
         s3_sat_in.rem  = RHSL_DIV_W'(num_sat[RHSL_SNUM_W-1:RHSL_QUO_W]);
         s3_sat_in.numq = num_sat[RHSL_QUO_W-1:0];
         s3_sat_in.dvs  = RHSL_DIV_W'({den, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_side_ff <= s3_side_in;
      s3_hue_ff  <= s3_hue_in;
      s3_sat_ff  <= s3_sat_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_side  = s3_side_ff;
   assign out_hue   = s3_hue_ff;
   assign out_sat   = s3_sat_ff;

endmodule

// ----- design/rhsl_div_step.sv -----
// ============================================================================
// rhsl_div_step: one restoring division step
// Brings down the next numerator bit, compares against the divisor and
// shifts the resulting quotient bit into the lane.
// ============================================================================
module rhsl_div_step (
   input  rhsl_pkg::rhsl_lane_type lane_i,
   output rhsl_pkg::rhsl_lane_type lane_o
);
   import rhsl_pkg::*;

   logic [RHSL_DIV_W:0] trial;
   logic [RHSL_DIV_W:0] trial_sub;
   logic                take;

   // Partial remainder with the next numerator bit appended.
   assign trial     = {lane_i.rem, lane_i.numq[RHSL_QUO_W-1]};
   assign trial_sub = trial - {1'b0, lane_i.dvs};
   assign take      = (trial >= {1'b0, lane_i.dvs});

   always_comb begin
      lane_o.dvs  = lane_i.dvs;
      lane_o.numq = {lane_i.numq[RHSL_QUO_W-2:0], take};
      lane_o.rem  = take ? trial_sub[RHSL_DIV_W-1:0] : trial[RHSL_DIV_W-1:0];
   end

endmodule

// ----- design/rhsl_div_pipe.sv -----
// ============================================================================
// rhsl_div_pipe: pipelined dual-lane divider
// One quotient bit per stage for the hue and saturation lanes side by side,
// with the valid bit and pixel sideband registered at every stage.
// ============================================================================
module rhsl_div_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  rhsl_pkg::rhsl_side_type in_side,
   input  rhsl_pkg::rhsl_lane_type in_hue,
   input  rhsl_pkg::rhsl_lane_type in_sat,
   output logic                    out_valid,
   output rhsl_pkg::rhsl_side_type out_side,
   output logic [rhsl_pkg::RHSL_QUO_W-1:0] out_hue_q,
   output logic [rhsl_pkg::RHSL_QUO_W-1:0] out_sat_q
);
   import rhsl_pkg::*;

   localparam int LAST = RHSL_QUO_W - 1;

   logic          valid_src [RHSL_QUO_W];
   rhsl_side_type side_src  [RHSL_QUO_W];
   rhsl_lane_type hue_src   [RHSL_QUO_W];
   rhsl_lane_type sat_src   [RHSL_QUO_W];
   rhsl_lane_type hue_in    [RHSL_QUO_W];
   rhsl_lane_type sat_in    [RHSL_QUO_W];
   logic          valid_ff  [RHSL_QUO_W];
   rhsl_side_type side_ff   [RHSL_QUO_W];
   rhsl_lane_type hue_ff    [RHSL_QUO_W];
   rhsl_lane_type sat_ff    [RHSL_QUO_W];

   // One divider step and one register stage per quotient bit.
   for (genvar g = 0; g < RHSL_QUO_W; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign valid_src[g] = in_valid;
         assign side_src[g]  = in_side;
         assign hue_src[g]   = in_hue;
         assign sat_src[g]   = in_sat;
      end else begin : g_next
         assign valid_src[g] = valid_ff[g-1];
         assign side_src[g]  = side_ff[g-1];
         assign hue_src[g]   = hue_ff[g-1];
         assign sat_src[g]   = sat_ff[g-1];
      end

      rhsl_div_step u_hue_step (
         .lane_i (hue_src[g]),
         .lane_o (hue_in[g])
      );

      rhsl_div_step u_sat_step (
         .lane_i (sat_src[g]),
         .lane_o (sat_in[g])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= valid_src[g];
         end
         side_ff[g] <= side_src[g];
         hue_ff[g]  <= hue_in[g];
         sat_ff[g]  <= sat_in[g];
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_side  = side_ff[LAST];
   assign out_hue_q = hue_ff[LAST].numq;
   assign out_sat_q = sat_ff[LAST].numq;

   // A request entering the divider leaves it a fixed number of stages later.
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##RHSL_QUO_W out_valid)
      else $error("divider valid did not arrive at the last stage");

   // The final remainders of a finished division stay below their divisors.
   a_hue_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |-> (hue_ff[LAST].rem < hue_ff[LAST].dvs))
      else $error("hue remainder not below divisor");

   a_sat_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |-> (sat_ff[LAST].rem < sat_ff[LAST].dvs))
      else $error("saturation remainder not below divisor");

endmodule

// ----- design/rgb_to_hsl_pixel.sv -----
// ============================================================================
// rgb_to_hsl_pixel: RGB to HSL pixel converter
// Converts one 8-bit RGB pixel per clock into a 16-bit hue in turns, a
// 16-bit saturation fraction and an 8-bit lightness.
// ============================================================================
//
// Usage:
//   A request (req_red, req_green, req_blue) is taken at a rising edge where
//   start is high and busy is low. busy is always low: the pipeline takes one
//   pixel in every clock with no bubbles.
//   Each request yields exactly one result on rsp_hue, rsp_saturation and
//   rsp_lightness, shown for one cycle with rsp_strobe high. Results leave in
//   request order.
//   Pipeline: a request passes three setup stages, seventeen divider stages
//   (one quotient bit each for the hue and saturation divisions, side by side)
//   and the output register. Throughput is one pixel per clock.
//   The receiver cannot stall the block; each result must be taken in the
//   cycle that rsp_strobe marks.
//   Synchronous reset clears every valid bit, dropping pixels in flight; no
//   result is shown until a new request has passed the pipeline.
//
module rgb_to_hsl_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_strobe,
   output logic [15:0] rsp_hue,
   output logic [15:0] rsp_saturation,
   output logic [7:0]  rsp_lightness
);
   import rhsl_pkg::*;

   logic                  accept;
   logic                  front_valid;
   rhsl_side_type         front_side;
   rhsl_lane_type         front_hue;
   rhsl_lane_type         front_sat;
   logic                  div_valid;
   rhsl_side_type         div_side;
   logic [RHSL_QUO_W-1:0] hue_q;
   logic [RHSL_QUO_W-1:0] sat_q;
   logic [RHSL_QUO_W:0]   hue_round;

   logic        strobe_ff;
   logic [15:0] hue_ff,   hue_in;
   logic [15:0] sat_ff,   sat_in;
   logic [7:0]  light_ff;

   // The pipeline never holds off a request.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   rhsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_hue   (front_hue),
      .out_sat   (front_sat)
   );

   rhsl_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_hue    (front_hue),
      .in_sat    (front_sat),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_hue_q (hue_q),
      .out_sat_q (sat_q)
   );

   // Round the hue half up from one extra quotient bit; a full turn wraps.
   assign hue_round = {1'b0, hue_q} + (RHSL_QUO_W + 1)'(1);

   always_comb begin
      if (div_side.gray) begin
         hue_in = 16'd0;
         sat_in = 16'd0;
      end else begin
         hue_in = hue_round[16:1];
         sat_in = sat_q[16] ? 16'hFFFF : sat_q[15:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= div_valid;
      end
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      light_ff <= div_side.lightness;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness  = light_ff;

   // Every request produces its result a fixed number of edges later.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RHSL_LATENCY rsp_strobe)
      else $error("result strobe missing after request");

   // Zero saturation only comes from a gray pixel, whose hue is zero too.
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_saturation == 16'd0)) |-> (rsp_hue == 16'd0))
      else $error("zero saturation with nonzero hue");

   // The saturation quotient never reaches a full 17 bits.
   a_sat_fit: assert property (@(posedge clock) disable iff (reset)
      div_valid |-> !sat_q[RHSL_QUO_W-1])
      else $error("saturation quotient overflow");

endmodule
